// ===== hdl/sgb_pkg.sv =====
// Shared constants, types and the coefficient selection function of the Gaussian blur unit.
package sgb_pkg;

  localparam int MAX_RADIUS  = 11;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COEF_BITS   = 16;
  localparam int TAPS        = 2 * MAX_RADIUS + 1;
  localparam int STORE_ROWS  = 2 * MAX_RADIUS;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int SLOT_BITS   = $clog2(STORE_ROWS);
  localparam int ADDR_BITS   = SLOT_BITS + COL_BITS;
  localparam int STORE_DEPTH = STORE_ROWS * MAX_WIDTH;
  localparam int TAP_BITS    = $clog2(TAPS);
  localparam int RAD_BITS    = 4;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int POS_BITS    = 23;
  localparam int COLSUM_BITS = COEF_BITS + 10;
  localparam int VACC_BITS   = COEF_BITS + 8 + 5;
  localparam int HPROD_BITS  = COEF_BITS + COLSUM_BITS;
  localparam int HACC_BITS   = HPROD_BITS + 5;
  localparam int OUT_SHIFT   = 2 * COEF_BITS - 8;
  localparam int SLOTS       = 12;

  typedef enum logic [2:0] {
    REG_WIDTH     = 3'd0,
    REG_HEIGHT    = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_COEF_LOW  = 3'd3,
    REG_COEF_MID  = 3'd4,
    REG_COEF_HIGH = 3'd5
  } cfg_reg_t;

  typedef logic [COLSUM_BITS-1:0] colsum_t;
  typedef colsum_t [2:0] colsum3_t;
  typedef logic [2:0][7:0] pix_t;
  typedef logic [2:0][VACC_BITS-1:0] vacc3_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic                 valid;
    logic                 cur;
    logic [COEF_BITS-1:0] coef;
    logic [ADDR_BITS-1:0] addr;
  } vtap_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_BITS-1:0] addr;
    logic [23:0]          data;
  } store_wr_t;

  // Coefficient for offset k; offsets past the last slot weigh zero.
  function automatic logic [COEF_BITS-1:0] coef_pick(input logic [3*64-1:0] bank,
                                                     input logic [TAP_BITS-1:0] k);
    logic [COEF_BITS-1:0] c;
    c = '0;
    if (k < TAP_BITS'(SLOTS)) begin
      c = bank[int'(k) * 16 +: COEF_BITS];
    end
    return c;
  endfunction

endpackage

// ===== hdl/separable_gaussian_blur_unit.sv =====
// Top level of the separable Gaussian blur unit: control, column sum chain and output stage.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_stall    operation, chan_a, chan_b, chan_c
//   out      output     out_valid / out_stall  out_a, out_b, out_c, frame_end
//   cfg      input      cfg_we                 cfg_index, cfg_data
//
// One item is worked on at a time. The vertical sum walks the 2R+1 rows of the column through
// the single read port of the line store, one row per cycle, and the horizontal sum rotates the
// 23-cell chain of column sums once around its ring, one cell per cycle.
// An item that yields a pixel also runs the horizontal sum; one that yields none skips it.
// Reset is synchronous; it clears counters, the chain and the output valid. The line store is
// not cleared: rows outside the frame are read but weighted with a zero coefficient.
// A stalled result waits in the output register; a new item is still taken while it waits,
// and only the final step of that item holds until the result register is free.
module separable_gaussian_blur_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  chan_a,
  input  logic [7:0]  chan_b,
  input  logic [7:0]  chan_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_a,
  output logic [15:0] out_b,
  output logic [15:0] out_c,
  output logic        frame_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sgb_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_VERT   = 7'b0000010,
    S_VDRAIN = 7'b0000100,
    S_SHIFT  = 7'b0001000,
    S_HORZ   = 7'b0010000,
    S_HDRAIN = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state, state_next;

  // Configuration registers and their effective values.
  logic [WIDTH_BITS-1:0]  cfg_w;
  logic [HEIGHT_BITS-1:0] cfg_h;
  logic [RAD_BITS-1:0]    cfg_r;
  logic [63:0]            coef_lo, coef_mid, coef_hi;
  logic [3*64-1:0]        bank;
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [RAD_BITS-1:0]    r_eff;
  logic [TAP_BITS-1:0]    two_r;
  logic [POS_BITS-1:0]    lag;
  logic                   restart;

  always_comb begin
    w_eff = cfg_w;
    if (cfg_w == '0) begin
      w_eff = WIDTH_BITS'(1);
    end else if (cfg_w > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end
    h_eff = cfg_h;
    if (cfg_h == '0) begin
      h_eff = HEIGHT_BITS'(1);
    end else if (cfg_h > HEIGHT_BITS'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_BITS'(MAX_HEIGHT);
    end
    r_eff = (cfg_r > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : cfg_r;
  end

  assign two_r   = {r_eff, 1'b0};
  assign bank    = {coef_hi, coef_mid, coef_lo};
  assign lag     = POS_BITS'(r_eff) * (POS_BITS'(w_eff) + POS_BITS'(1));
  assign restart = cfg_we && (cfg_index <= REG_COEF_HIGH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w    <= WIDTH_BITS'(512);
      cfg_h    <= HEIGHT_BITS'(512);
      cfg_r    <= RAD_BITS'(2);
      coef_lo  <= '0;
      coef_mid <= '0;
      coef_hi  <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH:     cfg_w    <= cfg_data[WIDTH_BITS-1:0];
        REG_HEIGHT:    cfg_h    <= cfg_data[HEIGHT_BITS-1:0];
        REG_RADIUS:    cfg_r    <= cfg_data[RAD_BITS-1:0];
        REG_COEF_LOW:  coef_lo  <= cfg_data;
        REG_COEF_MID:  coef_mid <= cfg_data;
        REG_COEF_HIGH: coef_hi  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame position counters.
  logic [HEIGHT_BITS-1:0] in_row;
  logic [COL_BITS-1:0]    in_col;
  logic [SLOT_BITS-1:0]   in_slot;
  logic [11:0]            out_row;
  logic [COL_BITS-1:0]    out_col;
  logic [POS_BITS-1:0]    pos;

  // The item being worked on.
  pix_t pix;
  logic in_frame;
  logic emit;
  logic [TAP_BITS-1:0] vcnt, hcnt;

  // Vertical tap request.
  vtap_t     tap;
  store_wr_t wr;
  vacc3_t    vacc;
  logic      vbusy;
  logic signed [HEIGHT_BITS+1:0] row_s;
  logic signed [SLOT_BITS+1:0]   slot_s;
  logic [SLOT_BITS-1:0]          slot;
  logic [TAP_BITS-1:0]           vdist;
  logic                          row_ok;

  always_comb begin
    row_s  = $signed({2'b0, in_row}) + $signed((HEIGHT_BITS+2)'(vcnt))
           - $signed((HEIGHT_BITS+2)'(two_r));
    row_ok = (row_s >= 0) && (row_s < $signed({2'b0, h_eff}));
    slot_s = $signed({2'b0, in_slot}) + $signed((SLOT_BITS+2)'(vcnt))
           - $signed((SLOT_BITS+2)'(two_r));
    if (slot_s < 0) begin
      slot_s = slot_s + $signed((SLOT_BITS+2)'(STORE_ROWS));
    end
    slot  = slot_s[SLOT_BITS-1:0];
    vdist = (vcnt >= TAP_BITS'(r_eff)) ? vcnt - TAP_BITS'(r_eff) : TAP_BITS'(r_eff) - vcnt;
    tap.valid = (state == S_VERT);
    tap.cur   = (vcnt == two_r);
    tap.coef  = row_ok ? coef_pick(bank, vdist) : '0;
    tap.addr  = {slot, in_col};
  end

  always_comb begin
    wr.en   = (state == S_FINISH) && !(emit && out_valid && out_stall) && in_frame;
    wr.addr = {in_slot, in_col};
    wr.data = {pix[2], pix[1], pix[0]};
  end

  sgb_vert u_vert (
    .clk   (clk),
    .rst   (rst),
    .clear (in_valid && !in_stall),
    .tap   (tap),
    .pix   (pix),
    .wr    (wr),
    .busy  (vbusy),
    .acc   (vacc)
  );

  // Column sum chain: shifts in a new sum once per item, then, for an item that emits, rotates
  // once around its ring while the horizontal sum reads the last cell.
  colsum3_t   newsum;
  colsum3_t   chain [0:TAPS];
  cell_ctrl_t cctl;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      newsum[ch] = (vacc[ch] > VACC_BITS'({COLSUM_BITS{1'b1}})) ?
                   {COLSUM_BITS{1'b1}} : vacc[ch][COLSUM_BITS-1:0];
    end
    cctl.shift = (state == S_SHIFT) || (state == S_HORZ);
    cctl.clear = restart || ((state == S_FINISH) && !(emit && out_valid && out_stall)
                             && emit && (out_row == 12'(h_eff - 1'b1))
                             && (out_col == COL_BITS'(w_eff - 1'b1)));
    chain[0]   = (state == S_HORZ) ? chain[TAPS] : newsum;
  end

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    sgb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctrl (cctl),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // Horizontal multiply-accumulate on the last cell of the chain.
  logic [TAP_BITS-1:0]           hj, hdist;
  logic signed [COL_BITS+2:0]    x_s;
  logic                          h_ok;
  logic [COEF_BITS-1:0]          hcoef;
  logic [2:0][HPROD_BITS-1:0]    hprod;
  logic                          hp_valid;
  logic [2:0][HACC_BITS-1:0]     hacc;
  logic [2:0][15:0]              res;
  logic [HACC_BITS-1:0]          rounded;

  always_comb begin
    hj    = TAP_BITS'(TAPS - 1) - hcnt;
    x_s   = $signed({3'b0, out_col}) + $signed((COL_BITS+3)'(r_eff))
          - $signed((COL_BITS+3)'(hj));
    h_ok  = (hj <= two_r) && (x_s >= 0) && (x_s < $signed({2'b0, w_eff}));
    hdist = (hj >= TAP_BITS'(r_eff)) ? hj - TAP_BITS'(r_eff) : TAP_BITS'(r_eff) - hj;
    hcoef = h_ok ? coef_pick(bank, hdist) : '0;
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      hprod[ch] <= hcoef * chain[TAPS][ch];
    end
    if (rst) begin
      hp_valid <= 1'b0;
    end else begin
      hp_valid <= (state == S_HORZ);
    end
    if (state == S_SHIFT) begin
      hacc <= '0;
    end else if (hp_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        hacc[ch] <= hacc[ch] + HACC_BITS'(hprod[ch]);
      end
    end
  end

  // Round half up, then saturate to 16 bits.
  always_comb begin
    rounded = '0;
    for (int ch = 0; ch < 3; ch++) begin
      rounded = (hacc[ch] + (HACC_BITS'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      res[ch] = (rounded > HACC_BITS'(16'hFFFF)) ? 16'hFFFF : rounded[15:0];
    end
  end

  // Sequencer.
  logic finish_go, last;

  assign finish_go = (state == S_FINISH) && !(emit && out_valid && out_stall);
  assign last      = (out_row == 12'(h_eff - 1'b1)) && (out_col == COL_BITS'(w_eff - 1'b1));
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (in_valid) state_next = S_VERT;
      S_VERT:   if (vcnt == two_r) state_next = S_VDRAIN;
      S_VDRAIN: if (!vbusy) state_next = S_SHIFT;
      S_SHIFT:  state_next = emit ? S_HORZ : S_FINISH;
      S_HORZ:   if (hcnt == TAP_BITS'(TAPS - 1)) state_next = S_HDRAIN;
      S_HDRAIN: if (!hp_valid) state_next = S_FINISH;
      S_FINISH: if (finish_go) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vcnt  <= '0;
      hcnt  <= '0;
    end else begin
      state <= state_next;
      vcnt  <= (state == S_VERT) ? vcnt + 1'b1 : '0;
      hcnt  <= (state == S_HORZ) ? hcnt + 1'b1 : '0;
    end
  end

  // Item capture; samples outside the frame or on a flush count as black.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_frame <= (in_row < h_eff);
      pix      <= ((in_row < h_eff) && !operation) ? {chan_c, chan_b, chan_a} : '0;
      emit     <= (pos >= lag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_row  <= '0;
      in_col  <= '0;
      in_slot <= '0;
      out_row <= '0;
      out_col <= '0;
      pos     <= '0;
    end else if (finish_go) begin
      if (emit && last) begin
        in_row  <= '0;
        in_col  <= '0;
        in_slot <= '0;
        out_row <= '0;
        out_col <= '0;
        pos     <= '0;
      end else begin
        pos <= pos + 1'b1;
        if ((WIDTH_BITS)'(in_col) + 1'b1 >= w_eff) begin
          in_col  <= '0;
          in_row  <= in_row + 1'b1;
          in_slot <= (in_slot == SLOT_BITS'(STORE_ROWS - 1)) ? '0 : in_slot + 1'b1;
        end else begin
          in_col <= in_col + 1'b1;
        end
        if (emit) begin
          if ((WIDTH_BITS)'(out_col) + 1'b1 >= w_eff) begin
            out_col <= '0;
            out_row <= out_row + 1'b1;
          end else begin
            out_col <= out_col + 1'b1;
          end
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (finish_go && emit) begin
      out_a     <= res[0];
      out_b     <= res[1];
      out_c     <= res[2];
      frame_end <= last;
    end
  end

  // An accepted item always starts with the vertical pass.
  a_accept_vert: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == S_VERT)
    else $error("accepted item did not start the vertical pass");

  // The chain is only shifted once the vertical pipeline has drained.
  a_shift_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> !vbusy)
    else $error("column sum shifted while vertical pipeline busy");

  // A new result is only loaded at the end of an item that emits.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH) && $past(emit))
    else $error("output loaded outside the final step");

  // Input column always stays within the row.
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    (WIDTH_BITS)'(in_col) < w_eff)
    else $error("input column beyond image width");

endmodule

// ===== hdl/sgb_cell.sv =====
// One cell of the column sum chain: three channel sums handed to the next cell.
module sgb_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  sgb_pkg::cell_ctrl_t  ctrl,
  input  sgb_pkg::colsum3_t    din,
  output sgb_pkg::colsum3_t    dout
);
  import sgb_pkg::*;

  colsum3_t sum;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.shift) begin
      sum <= din;
    end
  end

  assign dout = sum;

endmodule

// ===== hdl/sgb_vert.sv =====
// Line store and vertical multiply-accumulate over one column of taps.
module sgb_vert (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  sgb_pkg::vtap_t      tap,
  input  sgb_pkg::pix_t       pix,
  input  sgb_pkg::store_wr_t  wr,
  output logic                busy,
  output sgb_pkg::vacc3_t     acc
);
  import sgb_pkg::*;

  logic [23:0] mem [0:STORE_DEPTH-1];
  logic [23:0] rdata;
  logic        b_valid, b_cur, c_valid;
  logic [COEF_BITS-1:0] b_coef;
  logic [2:0][7:0] val;
  logic [2:0][COEF_BITS+7:0] prod;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[tap.addr];
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      val[ch] = b_cur ? pix[ch] : rdata[8*ch +: 8];
    end
  end

  always_ff @(posedge clk) begin
    b_cur  <= tap.cur;
    b_coef <= tap.coef;
    for (int ch = 0; ch < 3; ch++) begin
      prod[ch] <= b_coef * val[ch];
    end
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      b_valid <= tap.valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
    end else if (c_valid) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc[ch] <= acc[ch] + VACC_BITS'(prod[ch]);
      end
    end
  end

  assign busy = b_valid | c_valid;

endmodule
